/* hdl/cicgd_pkg.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell grid deposit package
// Shared constants, operation codes, register indexes and command types.
// ----------------------------------------------------------------------------
package cicgd_pkg;

  localparam int unsigned GRID_X_DEF = 64;
  localparam int unsigned GRID_Y_DEF = 64;
  localparam int unsigned GRID_Z_DEF = 64;

  localparam int CELL_W = 26;

  localparam logic [1:0] OP_DEPOSIT    = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP        = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_X  = 3'd3;
  localparam logic [2:0] REG_SCALE_Y  = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;

  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;
  localparam logic [15:0] HALF_CELL   = 16'h8000;
  localparam logic [16:0] ONE_Q16     = 17'h1_0000;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_idx;
    logic                     step_pos;
    logic [16:0]              w_near;
    logic [16:0]              w_far;
  } axis_t;

  typedef struct packed {
    logic [1:0]  opcode;
    axis_t       ax;
    axis_t       ay;
    axis_t       az;
    logic [17:0] cell_address;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic axis_t axis_finish(logic [63:0] prod, logic neg);
    logic [39:0]        gmag;
    logic signed [41:0] g;
    logic [15:0]        f;
    logic [15:0]        a;
    axis_t              r;
    gmag = neg ? 40'((prod + 64'h0000_0000_00FF_FFFF) >> 24) : prod[63:24];
    g = neg ? 42'(42'd0 - {2'b00, gmag}) : {2'b00, gmag};
    f = g[15:0];
    r.cell_idx = g[41:16];
    if (f[15]) begin
      a = f - HALF_CELL;
      r.step_pos = 1'b1;
    end else begin
      a = HALF_CELL - f;
      r.step_pos = 1'b0;
    end
    r.w_near = ONE_Q16 - {1'b0, a};
    r.w_far  = {1'b0, a};
    return r;
  endfunction

endpackage

/* hdl/cloud_in_cell_grid_deposit_top.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell grid deposit
// Deposits particles into a 3D density grid with trilinear weights and serves
// cell reads and read-and-clears.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The front end
// forms the origin difference, the 32x32 scale multiply and the weights in
// turn, waits while the queue is full and hands the result to a two-entry
// queue; the deposit engine then reads one cell for a read, or for a deposit
// puts each of the eight corners through a two-step weight multiply and a
// read-modify-write of the single density memory. Results appear with
// result_valid_o high for one cycle only and must be captured then; the
// receiver cannot stall the block. After reset the density memory is zeroed
// one cell per cycle, which keeps busy high until every cell is cleared;
// configuration writes are taken at any time.
module cloud_in_cell_grid_deposit_top #(
  parameter int unsigned GRID_X = cicgd_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = cicgd_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = cicgd_pkg::GRID_Z_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [17:0] cell_address_i,
  output logic        result_valid_o,
  output logic [31:0] cell_value_o,
  output logic [3:0]  dropped_corners_o,
  output logic        saturated_o
);

  logic                    accept, front_busy, push, pop, full, empty;
  cicgd_pkg::cmd_t         push_cmd, pop_cmd;
  cicgd_pkg::back_status_t back_status;

  assign busy   = front_busy || back_status.clearing;
  assign accept = start && !busy;

  cicgd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .cell_address_i (cell_address_i),
    .full_i         (full),
    .busy_o         (front_busy),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  cicgd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  cicgd_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .cmd_i             (pop_cmd),
    .pop_o             (pop),
    .status_o          (back_status),
    .result_valid_o    (result_valid_o),
    .cell_value_o      (cell_value_o),
    .dropped_corners_o (dropped_corners_o),
    .saturated_o       (saturated_o)
  );

endmodule

/* hdl/cicgd_front.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell front end
// Holds the configuration, takes transactions and turns positions into cells
// and per-axis weights.
// ----------------------------------------------------------------------------
module cicgd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [1:0]           opcode_i,
  input  logic [31:0]          pos_x_i,
  input  logic [31:0]          pos_y_i,
  input  logic [31:0]          pos_z_i,
  input  logic [17:0]          cell_address_i,
  input  logic                 full_i,
  output logic                 busy_o,
  output logic                 push_o,
  output cicgd_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_FIN  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] origin_q [3];
  logic [31:0] scale_q [3];
  logic [31:0] pos_a [3];
  logic [31:0] mag_q [3];
  logic        neg_q [3];
  logic [63:0] prod_q [3];
  logic [1:0]  op_q;
  logic [17:0] addr_q;

  assign pos_a[0] = pos_x_i;
  assign pos_a[1] = pos_y_i;
  assign pos_a[2] = pos_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        scale_q[i]  <= cicgd_pkg::SCALE_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cicgd_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_wdata_i;
        cicgd_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i;
        cicgd_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i;
        cicgd_pkg::REG_SCALE_X:  scale_q[0]  <= cfg_wdata_i;
        cicgd_pkg::REG_SCALE_Y:  scale_q[1]  <= cfg_wdata_i;
        cicgd_pkg::REG_SCALE_Z:  scale_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept_i) state_d = F_MUL;
      F_MUL:   state_d = F_FIN;
      F_FIN:   if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] diff;
    if (state_q == F_IDLE && accept_i) begin
      op_q   <= opcode_i;
      addr_q <= cell_address_i;
      for (int i = 0; i < 3; i++) begin
        diff = {pos_a[i][31], pos_a[i]} - {origin_q[i][31], origin_q[i]};
        neg_q[i] <= diff[32];
        mag_q[i] <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
      end
    end
    if (state_q == F_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 64'(mag_q[i]) * 64'(scale_q[i]);
      end
    end
  end

  always_comb begin
    cmd_o.opcode       = op_q;
    cmd_o.ax           = cicgd_pkg::axis_finish(prod_q[0], neg_q[0]);
    cmd_o.ay           = cicgd_pkg::axis_finish(prod_q[1], neg_q[1]);
    cmd_o.az           = cicgd_pkg::axis_finish(prod_q[2], neg_q[2]);
    cmd_o.cell_address = addr_q;
  end

  assign push_o = (state_q == F_FIN) && !full_i;
  assign busy_o = (state_q != F_IDLE);

endmodule

/* hdl/cicgd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell command queue
// Two-entry queue that decouples the front end from the deposit engine.
// ----------------------------------------------------------------------------
module cicgd_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cicgd_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output cicgd_pkg::cmd_t cmd_o
);

  cicgd_pkg::cmd_t entry_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= cmd_i;
  end

  assign cmd_o   = entry_q[rptr_q];
  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);

endmodule

/* hdl/cicgd_back.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit engine
// Owns the density memory, clears it after reset and executes reads, clears
// and eight-corner deposits.
// ----------------------------------------------------------------------------
module cicgd_back #(
  parameter int unsigned GRID_X = cicgd_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = cicgd_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = cicgd_pkg::GRID_Z_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  cicgd_pkg::cmd_t         cmd_i,
  output logic                    pop_o,
  output cicgd_pkg::back_status_t status_o,
  output logic                    result_valid_o,
  output logic [31:0]             cell_value_o,
  output logic [3:0]              dropped_corners_o,
  output logic                    saturated_o
);

  localparam int unsigned NUM_CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(NUM_CELLS);
  localparam int CW = cicgd_pkg::CELL_W + 1;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_RD    = 3'd2;
  localparam logic [2:0] B_RDD   = 3'd3;
  localparam logic [2:0] B_C1    = 3'd4;
  localparam logic [2:0] B_C2    = 3'd5;
  localparam logic [2:0] B_C3    = 3'd6;

  logic [31:0]       mem [NUM_CELLS];
  logic [31:0]       rdata_q;
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [31:0]       wd;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q;
  cicgd_pkg::cmd_t   cur_q;
  logic [2:0]        corner_q;
  logic [3:0]        drop_q, drop_d;
  logic              sat_q, sat_d;
  logic              inr_q;
  logic [ADDR_W-1:0] idx_q;
  logic [33:0]       p1_q;
  logic [16:0]       wz_q;
  logic [50:0]       p2_q;
  logic              addr_ok;
  logic [32:0]       sum;
  logic [16:0]       wgt;
  logic              valid_q;
  logic [31:0]       value_q;
  logic [3:0]        dropped_q;
  logic              satout_q;

  function automatic logic signed [CW-1:0] coord(cicgd_pkg::axis_t a, logic sel);
    logic signed [CW-1:0] off;
    off = sel ? (a.step_pos ? CW'(1) : -CW'(1)) : CW'(0);
    return $signed({a.cell_idx[cicgd_pkg::CELL_W-1], a.cell_idx}) + off;
  endfunction

  assign addr_ok = ({14'd0, cur_q.cell_address} < 32'(NUM_CELLS));
  assign wgt     = 17'((p2_q + 51'h0_8000_0000) >> 32);
  assign sum     = {1'b0, rdata_q} + 33'(wgt);

  always_comb begin
    we = 1'b0;
    wa = idx_q;
    wd = '0;
    ra = idx_q;
    unique case (state_q)
      B_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
      end
      B_RD: ra = ADDR_W'(cur_q.cell_address);
      B_RDD: begin
        wa = ADDR_W'(cur_q.cell_address);
        we = addr_ok && (cur_q.opcode == cicgd_pkg::OP_READ_CLEAR);
      end
      B_C3: begin
        we = inr_q;
        wd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[ra];
  end

  always_comb begin
    drop_d = drop_q + {3'd0, !inr_q};
    sat_d  = sat_q || (inr_q && sum[32]);
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      B_CLEAR: if (clr_q == ADDR_W'(NUM_CELLS - 1)) state_d = B_IDLE;
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.opcode)
            cicgd_pkg::OP_DEPOSIT:    state_d = B_C1;
            cicgd_pkg::OP_READ:       state_d = B_RD;
            cicgd_pkg::OP_READ_CLEAR: state_d = B_RD;
            cicgd_pkg::OP_NOP:        state_d = B_IDLE;
          endcase
        end
      end
      B_RD:    state_d = B_RDD;
      B_RDD:   state_d = B_IDLE;
      B_C1:    state_d = B_C2;
      B_C2:    state_d = B_C3;
      B_C3:    state_d = (corner_q == 3'd7) ? B_IDLE : B_C1;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      valid_q <= (state_q == B_IDLE && !empty_i && cmd_i.opcode == cicgd_pkg::OP_NOP)
              || (state_q == B_RDD) || (state_q == B_C3 && corner_q == 3'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] x, y, z;
    logic                 ok;
    if (state_q == B_IDLE && !empty_i) begin
      cur_q     <= cmd_i;
      corner_q  <= 3'd0;
      drop_q    <= 4'd0;
      sat_q     <= 1'b0;
      value_q   <= '0;
      dropped_q <= 4'd0;
      satout_q  <= 1'b0;
    end
    if (state_q == B_C1) begin
      x  = coord(cur_q.ax, corner_q[2]);
      y  = coord(cur_q.ay, corner_q[1]);
      z  = coord(cur_q.az, corner_q[0]);
      ok = !x[CW-1] && (x < $signed(CW'(GRID_X))) && !y[CW-1] &&
           (y < $signed(CW'(GRID_Y))) && !z[CW-1] && (z < $signed(CW'(GRID_Z)));
      inr_q <= ok;
      idx_q <= ADDR_W'(32'(z) + 32'(GRID_Z) * (32'(y) + 32'(GRID_Y) * 32'(x)));
      p1_q  <= 34'(corner_q[2] ? cur_q.ax.w_far : cur_q.ax.w_near) *
               34'(corner_q[1] ? cur_q.ay.w_far : cur_q.ay.w_near);
      wz_q  <= corner_q[0] ? cur_q.az.w_far : cur_q.az.w_near;
    end
    if (state_q == B_C2) begin
      p2_q <= 51'(p1_q) * 51'(wz_q);
    end
    if (state_q == B_C3) begin
      drop_q   <= drop_d;
      sat_q    <= sat_d;
      corner_q <= corner_q + 3'd1;
      if (corner_q == 3'd7) begin
        value_q   <= '0;
        dropped_q <= drop_d;
        satout_q  <= sat_d;
      end
    end
    if (state_q == B_RDD) begin
      value_q   <= addr_ok ? rdata_q : 32'd0;
      dropped_q <= 4'd0;
      satout_q  <= 1'b0;
    end
  end

  assign status_o.clearing = (state_q == B_CLEAR);
  assign result_valid_o    = valid_q;
  assign cell_value_o      = value_q;
  assign dropped_corners_o = dropped_q;
  assign saturated_o       = satout_q;

endmodule

/* hdl/cicgd_checker.sv */
// ----------------------------------------------------------------------------
// Cloud-in-cell port checker
// Checks port-level behavior of the grid deposit block over time.
// ----------------------------------------------------------------------------
module cicgd_assertions (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [31:0] cell_value_o,
  input logic [3:0]  dropped_corners_o,
  input logic        saturated_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_deposit_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (dropped_corners_o != 4'd0 || saturated_o) |-> cell_value_o == 32'd0)
    else $error("deposit result carries a cell value");

  a_dropped_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> dropped_corners_o <= 4'd8)
    else $error("more than eight dropped corners");

endmodule

bind cloud_in_cell_grid_deposit_top cicgd_assertions u_cicgd_assertions (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .cell_value_o      (cell_value_o),
  .dropped_corners_o (dropped_corners_o),
  .saturated_o       (saturated_o)
);
